@@ src/sha256_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 message hasher.
package sha256_pkg;

  localparam int NUM_CHAIN = 8;
  localparam int SCHED_DEPTH = 16;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;

  localparam logic [31:0] INIT_H [NUM_CHAIN] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       start;
    logic       pad;
    logic       len_blk;
    logic       round;
    logic       add;
    logic       emit;
    logic [5:0] rnd;
  } sha256_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_full;
    logic pad_two;
    logic out_busy;
  } sha256_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Pads one schedule word: bytes before the fill point stay, the byte at it
  // becomes the pad mark and the bytes after it are cleared.
  function automatic logic [31:0] pad_word(input logic [31:0] wd, input logic [3:0] j,
                                           input logic [5:0] f);
    logic [31:0] r;
    logic [5:0]  p;
    r = wd;
    for (int b = 0; b < 4; b++) begin
      p = {j, 2'(b)};
      if (p == f) begin
        r[8*(3-b) +: 8] = PAD_MARK;
      end else if (p > f) begin
        r[8*(3-b) +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

endpackage

@@ src/sha256_ctrl.sv @@
// Controller state machine that sequences byte intake, padding, rounds and digest hand-off.
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_has,
  input  logic        in_last,
  output logic        in_ready,
  input  sha256_sts_t sts,
  output sha256_cmd_t cmd
);

  ctrl_state_t state, state_next;
  ctrl_state_t ret, ret_next;
  logic [5:0]  rnd, rnd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rnd   <= rnd_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    rnd_next   = rnd;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rnd    = rnd;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = in_has;
          if (in_has && sts.fill_full) begin
            cmd.start  = 1'b1;
            rnd_next   = '0;
            state_next = ST_ROUND;
            ret_next   = in_last ? ST_PAD : ST_IDLE;
          end else if (in_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad    = 1'b1;
        cmd.start  = 1'b1;
        rnd_next   = '0;
        ret_next   = sts.pad_two ? ST_LEN : ST_EMIT;
        state_next = ST_ROUND;
      end
      ST_LEN: begin
        cmd.len_blk = 1'b1;
        cmd.start   = 1'b1;
        rnd_next    = '0;
        ret_next    = ST_EMIT;
        state_next  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == ROUND_LAST) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ret;
      end
      ST_EMIT: begin
        // The digest waits here until the previous one has fully drained.
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == ROUND_LAST) |=> state == ST_ADD)
    else $error("compression did not end after the last round");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy)
    else $error("digest loaded over words not yet delivered");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD || state == ST_LEN) |=> (state == ST_ROUND && rnd == 6'd0))
    else $error("padded block did not start at round zero");

endmodule

@@ src/sha256_dp.sv @@
// Datapath: message schedule, working variables, chaining words, counters and digest register.
module sha256_dp
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sha256_cmd_t cmd,
  input  logic [7:0]  data_byte,
  output sha256_sts_t sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index
);

  logic [31:0] w [SCHED_DEPTH];
  logic [31:0] v [NUM_CHAIN];
  logic [31:0] chain [NUM_CHAIN];
  logic [31:0] out_words [NUM_CHAIN];
  logic [5:0]  fill;
  logic [63:0] msg;
  logic [63:0] len_bits;
  logic [31:0] t1, t2, ch, maj, w_new;
  logic        pad_two;

  assign pad_two  = fill >= LEN_OFFSET;
  assign len_bits = {msg[60:0], 3'b000};

  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + bsig1(v[4]) + ch + round_k(cmd.rnd) + w[0];
  assign t2    = bsig0(v[0]) + maj;
  assign w_new = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];

  assign sts.fill_full = fill == FILL_LAST;
  assign sts.pad_two   = pad_two;
  assign sts.out_busy  = out_valid;

  assign digest_word = out_words[0];

  // Control-side state: chaining words and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INIT_H;
      fill  <= '0;
      msg   <= '0;
    end else begin
      if (cmd.take) begin
        fill <= fill + 6'd1;
        msg  <= msg + 64'd1;
      end
      if (cmd.add) begin
        for (int i = 0; i < NUM_CHAIN; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
      if (cmd.emit) begin
        chain <= INIT_H;
        fill  <= '0;
        msg   <= '0;
      end
    end
  end

  // Schedule words: bytes land big-endian; during rounds the line shifts by one word.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      w[fill[5:2]][8*(3-fill[1:0]) +: 8] <= data_byte;
    end
    if (cmd.pad) begin
      for (int j = 0; j < SCHED_DEPTH - 2; j++) begin
        w[j] <= pad_word(w[j], 4'(j), fill);
      end
      if (pad_two) begin
        w[14] <= pad_word(w[14], 4'd14, fill);
        w[15] <= pad_word(w[15], 4'd15, fill);
      end else begin
        w[14] <= len_bits[63:32];
        w[15] <= len_bits[31:0];
      end
    end
    if (cmd.len_blk) begin
      for (int j = 0; j < SCHED_DEPTH - 2; j++) begin
        w[j] <= '0;
      end
      w[14] <= len_bits[63:32];
      w[15] <= len_bits[31:0];
    end
    if (cmd.round) begin
      for (int j = 0; j < SCHED_DEPTH - 1; j++) begin
        w[j] <= w[j+1];
      end
      w[SCHED_DEPTH-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v <= chain;
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Digest output register drains one word per handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      word_index <= '0;
    end else if (cmd.emit) begin
      out_valid  <= 1'b1;
      word_index <= '0;
    end else if (out_valid && out_ready) begin
      word_index <= word_index + 3'd1;
      if (word_index == 3'd7) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_words <= chain;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < NUM_CHAIN - 1; i++) begin
        out_words[i] <= out_words[i+1];
      end
    end
  end

endmodule

@@ src/sha256_message_hasher.sv @@
// Top level of the byte-serial SHA-256 message hasher.
// A byte word is taken whenever the input is ready; the 64th byte of a block holds the input off
// for the 64 rounds on one shared round unit and then the chaining add.
// A last word adds the padded block, a further length block when fewer than 9 bytes of room
// remain, and the load of the digest register; the eight digest words then leave
// one per cycle when m_axis_tready is high, while the next message is already being taken in.
// Reset is synchronous and returns the chaining words, counters and controller to start.
module sha256_message_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word [31:0], word_index [34:32], zero fill
  output logic        m_axis_tlast    // final_word
);

  sha256_cmd_t cmd;
  sha256_sts_t sts;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_has   (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (s_axis_tdata),
    .sts         (sts),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign m_axis_tdata = {5'b00000, word_index, digest_word};
  assign m_axis_tlast = word_index == 3'd7;

endmodule
